// ===== design/clst_pkg.sv =====
package clst_pkg;

  localparam int CmdW   = 2;
  localparam int ValueW = 32;
  localparam int IndexW = 3;
  localparam int CountW = 4;

  // positions reachable through the index field
  localparam int IndexSpan = 1 << IndexW;

  localparam logic [CmdW-1:0] CmdAppend = 2'd0;
  localparam logic [CmdW-1:0] CmdErase  = 2'd1;
  localparam logic [CmdW-1:0] CmdSearch = 2'd2;
  localparam logic [CmdW-1:0] CmdRead   = 2'd3;

  localparam logic [CountW-1:0] CapacityReset = 4'd5;

  typedef logic signed [ValueW-1:0] value_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic active;
  } cell_ctl_t;

endpackage

// ===== design/clst_cell.sv =====
module clst_cell (
  input  logic              clk,
  input  clst_pkg::cell_ctl_t ctl,
  input  clst_pkg::value_t  value,
  input  clst_pkg::value_t  next_entry,
  output clst_pkg::value_t  entry,
  output logic              match
);
  import clst_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= value;
    end else if (ctl.shift) begin
      entry <= next_entry;
    end
  end

  assign match = ctl.active && (entry == value);

endmodule

// ===== design/compacting_list_store_top.sv =====
// compacting list store: one command per transaction, one result per command
// latency: result is registered, visible the cycle after the command is taken
// throughput: one command per cycle while the output is not stalled; append, erase shift and search compare
//   all happen in parallel across the row of entry cells
// reset (rst, synchronous): list empties, capacity returns to 5, no result
//   pending; entry contents are not cleared
module compacting_list_store_top #(
  parameter int DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [clst_pkg::CmdW-1:0]      command,
  input  logic signed [clst_pkg::ValueW-1:0] value,
  input  logic [clst_pkg::IndexW-1:0]    index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           ok,
  output logic [clst_pkg::IndexW-1:0]    found_index,
  output logic signed [clst_pkg::ValueW-1:0] item_value,
  output logic [clst_pkg::CountW-1:0]    count,
  input  logic                           cfg_we,
  input  logic [clst_pkg::CountW-1:0]    cfg_data
);
  import clst_pkg::*;

  localparam int DepthBits = $clog2(DEPTH) + 1;
  localparam int PosW = (DepthBits > CountW) ? DepthBits : CountW;
  localparam int MaxCount = (1 << CountW) - 1;
  localparam logic [CountW-1:0] DepthCap = CountW'((DEPTH > MaxCount) ? MaxCount : DEPTH);

  logic [CountW-1:0] capacity;
  logic [CountW-1:0] fill;
  logic [CountW-1:0] fill_next;
  logic [CountW-1:0] limit;
  logic              accept;

  logic              ok_next;
  logic [IndexW-1:0] found_next;
  value_t            item_next;

  value_t            entry [DEPTH];
  logic [DEPTH-1:0]  match;
  value_t            rd_view [IndexSpan];

  logic [PosW-1:0]   fill_ext;
  logic [PosW-1:0]   idx_ext;
  logic              idx_valid;
  logic              is_append;
  logic              is_erase;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  assign limit     = (capacity < DepthCap) ? capacity : DepthCap;
  assign fill_ext  = PosW'(fill);
  assign idx_ext   = PosW'(index);
  assign idx_valid = idx_ext < fill_ext;
  assign is_append = accept && (command == CmdAppend) && (fill < limit);
  assign is_erase  = accept && (command == CmdErase) && idx_valid;

  // row of entry cells; on erase, cells from the erased index up take their upper neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [PosW-1:0] Pos = PosW'(i);
    cell_ctl_t ctl;
    value_t    nbr;

    assign ctl.load   = is_append && (fill_ext == Pos);
    assign ctl.shift  = is_erase && (Pos >= idx_ext) && (Pos + PosW'(1) < fill_ext);
    assign ctl.active = Pos < fill_ext;

    if (i + 1 < DEPTH) begin : g_nbr
      assign nbr = entry[i+1];
    end else begin : g_last
      assign nbr = entry[i];
    end

    clst_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .value     (value),
      .next_entry(nbr),
      .entry     (entry[i]),
      .match     (match[i])
    );
  end

  for (genvar k = 0; k < IndexSpan; k++) begin : g_view
    if (k < DEPTH) begin : g_real
      assign rd_view[k] = entry[k];
    end else begin : g_pad
      assign rd_view[k] = '0;
    end
  end

  always_comb begin
    ok_next    = 1'b0;
    found_next = '0;
    item_next  = '0;
    fill_next  = fill;
    unique case (command)
      CmdAppend: begin
        if (fill < limit) begin
          ok_next   = 1'b1;
          fill_next = fill + CountW'(1);
        end
      end
      CmdErase: begin
        if (idx_valid) begin
          ok_next   = 1'b1;
          fill_next = fill - CountW'(1);
        end
      end
      CmdSearch: begin
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (match[i]) begin
            ok_next    = 1'b1;
            found_next = IndexW'(i);
          end
        end
      end
      CmdRead: begin
        if (idx_valid) begin
          ok_next   = 1'b1;
          item_next = rd_view[index];
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapacityReset;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok          <= ok_next;
      found_index <= found_next;
      item_value  <= item_next;
      count       <= fill_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= DepthCap)
    else $error("fill count beyond store depth");

  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CmdAppend && ok_next) |=> fill == $past(fill) + CountW'(1))
    else $error("append did not grow the list");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    accept |=> count == fill)
    else $error("reported count differs from fill count");
`endif

endmodule
